// ===== rtl/der_integer_sequence_parser_macros.svh =====
// Assertion macros shared by the DER integer sequence parser RTL.
`ifndef DER_INTEGER_SEQUENCE_PARSER_MACROS_SVH
`define DER_INTEGER_SEQUENCE_PARSER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define DISP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define DISP_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/disp_pkg.sv =====
// Types and constants for the DER integer sequence parser.
package disp_pkg;

  // Fixed protocol constants
  localparam logic [7:0]  SEQ_TAG     = 8'h30;
  localparam logic [7:0]  INT_TAG     = 8'h02;
  localparam logic [7:0]  MAX_INT_LEN = 8'd16;
  localparam logic [3:0]  MAX_FIELDS  = 4'd9;
  localparam logic [15:0] MIN_SIZE    = 16'd2;

  // Result status codes
  localparam logic [1:0] STATUS_INT = 2'd0;
  localparam logic [1:0] STATUS_REJ = 2'd1;
  localparam logic [1:0] STATUS_HDR = 2'd2;

  // Parser modes
  typedef enum logic [2:0] {
    MODE_SEQ_TAG,
    MODE_SEQ_LEN,
    MODE_TAG,
    MODE_LEN,
    MODE_BODY,
    MODE_IDLE
  } mode_e;

  // Input item: one message byte
  typedef struct packed {
    logic        first_of_message;
    logic [15:0] message_size;
    logic [7:0]  data_byte;
  } disp_in_t;

  // Result item: one decoded or rejected field
  typedef struct packed {
    logic [3:0]  field_index;
    logic [63:0] value;
    logic [1:0]  status;
  } disp_out_t;

endpackage

// ===== rtl/der_integer_sequence_parser.sv =====
// Top level of the DER integer sequence parser: input and result registers.
//
// Usage: feed one DER message byte per input item on the in_* valid/ready
// channel, with first_of_message set and message_size given on byte 0.
// The block checks the SEQUENCE header (tag 0x30, length = size - 2) and
// then decodes up to nine tag-length-value fields. Each field gives one
// result item on the out_* channel: the low 64 bits of a tag-2 integer of
// length up to 16, or a rejected status with value zero. A bad header gives
// one header-rejected item; the rest of that message is dropped.
// The byte that completes a field passes the input register and then the
// result register before its result leaves. Throughput: one byte per
// cycle while the result register is empty or being taken, set by the
// combinational parse between the two registers; bytes that finish no
// field give no item. Reset clears the parser to wait for the first byte
// of a message and empties both registers. When the receiver stalls, the
// waiting result is held; one further byte is taken into the input
// register, after which in_ready_o falls until the result is taken.
`include "der_integer_sequence_parser_macros.svh"

module der_integer_sequence_parser import disp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  disp_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output disp_out_t out_data_o
);

  logic      s1_valid_q;
  disp_in_t  s1_data_q;
  logic      out_valid_q;
  disp_out_t out_data_q;
  logic      advance;
  logic      res_valid;
  disp_out_t res;

  assign advance     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Hold the accepted byte in the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) s1_data_q <= in_data_i;
  end

  disp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (advance),
    .item_i      (s1_data_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Load the result register, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) out_data_q <= res;
  end

  // Assertions
  `DISP_ASSERT(a_status_known, !out_valid_q || out_data_q.status != 2'd3, "bad status")
  `DISP_ASSERT(a_hdr_zero, !(out_valid_q && out_data_q.status == STATUS_HDR) || (out_data_q.value == 64'd0 && out_data_q.field_index == 4'd0), "header item not zero")
  `DISP_ASSERT(a_rej_zero, !(out_valid_q && out_data_q.status == STATUS_REJ) || out_data_q.value == 64'd0, "rejected field not zero")
  `DISP_ASSERT(a_index_range, !out_valid_q || out_data_q.field_index < MAX_FIELDS, "field index out of range")
  `DISP_ASSERT_NEXT(a_s1_hold, s1_valid_q && !advance, s1_valid_q && $stable(s1_data_q), "input register lost an item")

endmodule

// ===== rtl/disp_core.sv =====
// Byte-wise DER sequence parser state and result formation.
module disp_core import disp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  disp_in_t  item_i,
  output logic      res_valid_o,
  output disp_out_t res_o
);

  mode_e       mode_q, mode_d;
  logic [15:0] pos_q, pos_d;
  logic [15:0] size_q, size_d;
  logic [3:0]  done_q, done_d;
  logic [7:0]  left_q, left_d;
  logic [63:0] acc_q, acc_d;
  logic        ok_q, ok_d;

  logic        emit;
  logic        hdr_err;
  logic [7:0]  missing;
  logic        last;
  logic [3:0]  done_inc;
  logic        fields_full;
  logic [7:0]  b;
  logic [7:0]  left_dec;

  assign b           = item_i.data_byte;
  assign last        = (pos_q == size_q - 16'd1);
  assign done_inc    = done_q + 4'd1;
  assign fields_full = (done_inc >= MAX_FIELDS);
  assign left_dec    = left_q - 8'd1;

  // Decode the byte and work out the next parser state
  always_comb begin
    mode_d  = mode_q;
    pos_d   = pos_q;
    size_d  = size_q;
    done_d  = done_q;
    left_d  = left_q;
    acc_d   = acc_q;
    ok_d    = ok_q;
    emit    = 1'b0;
    hdr_err = 1'b0;
    missing = '0;
    if (fire_i) begin
      if (item_i.first_of_message || mode_q == MODE_SEQ_TAG) begin
        size_d = item_i.message_size;
        pos_d  = 16'd1;
        done_d = '0;
        left_d = '0;
        acc_d  = '0;
        ok_d   = 1'b0;
        if (b != SEQ_TAG || item_i.message_size < MIN_SIZE) begin
          hdr_err = 1'b1;
          mode_d  = MODE_IDLE;
        end else begin
          mode_d = MODE_SEQ_LEN;
        end
      end else if (mode_q != MODE_IDLE) begin
        pos_d = pos_q + 16'd1;
        unique case (mode_q)
          MODE_SEQ_LEN: begin
            if ({8'd0, b} != size_q - MIN_SIZE) begin
              hdr_err = 1'b1;
              mode_d  = MODE_IDLE;
            end else begin
              mode_d = last ? MODE_IDLE : MODE_TAG;
            end
          end
          MODE_TAG: begin
            ok_d   = (b == INT_TAG);
            acc_d  = '0;
            left_d = '0;
            if (last) begin
              emit   = 1'b1;
              mode_d = MODE_IDLE;
            end else begin
              mode_d = MODE_LEN;
            end
          end
          MODE_LEN: begin
            if (b > MAX_INT_LEN) ok_d = 1'b0;
            left_d = b;
            if (b == 8'd0) begin
              emit   = 1'b1;
              mode_d = (last || fields_full) ? MODE_IDLE : MODE_TAG;
            end else if (last) begin
              emit    = 1'b1;
              missing = b;
              mode_d  = MODE_IDLE;
            end else begin
              mode_d = MODE_BODY;
            end
          end
          MODE_BODY: begin
            if (ok_q) acc_d = {acc_q[55:0], b};
            left_d = left_dec;
            if (left_dec == 8'd0) begin
              emit   = 1'b1;
              mode_d = (last || fields_full) ? MODE_IDLE : MODE_TAG;
            end else if (last) begin
              emit    = 1'b1;
              missing = left_dec;
              mode_d  = MODE_IDLE;
            end
          end
          default: mode_d = MODE_IDLE;
        endcase
        if (emit) done_d = done_inc;
      end
    end
  end

  // Form the result item
  always_comb begin
    res_valid_o       = emit || hdr_err;
    res_o.field_index = '0;
    res_o.value       = '0;
    res_o.status      = STATUS_HDR;
    if (emit) begin
      res_o.field_index = done_q;
      res_o.status      = ok_d ? STATUS_INT : STATUS_REJ;
      if (ok_d && missing < 8'd8) begin
        res_o.value = acc_d << {missing[2:0], 3'b000};
      end
    end
  end

  // Hold the parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SEQ_TAG;
      pos_q  <= '0;
      size_q <= '0;
      done_q <= '0;
      left_q <= '0;
      acc_q  <= '0;
      ok_q   <= 1'b0;
    end else begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      size_q <= size_d;
      done_q <= done_d;
      left_q <= left_d;
      acc_q  <= acc_d;
      ok_q   <= ok_d;
    end
  end

endmodule
